/* src/mono_page_framebuffer_text_top_macros.svh */
// assertion macros shared by the mono page framebuffer text block
// no dependencies; included by the controller and the datapath
`ifndef MONO_PAGE_FRAMEBUFFER_TEXT_TOP_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_TEXT_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define MPFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define MPFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mpft_pkg.sv */
// shared constants, codes and controller/datapath interface types
// no dependencies
package mpft_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 32;
	localparam int GLYPH_WORDS   = 4096;

	localparam int FB_PAGES  = (SCREEN_HEIGHT + 7) / 8;
	localparam int FB_BYTES  = SCREEN_WIDTH * FB_PAGES;
	localparam int FB_AW     = $clog2(FB_BYTES);
	localparam int FB_CALC_W = 16;
	localparam int GL_AW     = $clog2(GLYPH_WORDS);
	localparam int GL_CALC_W = 14;

	localparam logic [7:0] CODE_FIRST = 8'd32;
	localparam logic [7:0] CODE_LAST  = 8'd126;
	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

	// configuration register indexes
	localparam logic [1:0] CFG_INVERT  = 2'd0;
	localparam logic [1:0] CFG_GWIDTH  = 2'd1;
	localparam logic [1:0] CFG_GHEIGHT = 2'd2;

	typedef enum logic [2:0] {
		MODE_PIXEL  = 3'd0,
		MODE_FILL   = 3'd1,
		MODE_CURSOR = 3'd2,
		MODE_CHAR   = 3'd3,
		MODE_LOAD   = 3'd4,
		MODE_READ   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NOROOM  = 2'd1,
		STAT_BADCODE = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    decode;
		logic    set_status;
		status_t status_val;
		logic    sweep_wr;
		logic    sweep_fill;
		logic    pix_char;
		logic    fb_rd;
		logic    fb_rd_byte;
		logic    fb_wr_pix;
		logic    rd_latch;
		logic    gl_wr;
		logic    gl_rd;
		logic    gl_latch;
		logic    row_clr;
		logic    row_inc;
		logic    col_clr;
		logic    col_inc;
		logic    cur_set;
		logic    cur_adv;
		logic    out_load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       pix_ok;
		logic       code_ok;
		logic       room_ok;
		logic       load_ok;
		logic       read_ok;
		logic       sweep_last;
		logic       row_done;
		logic       col_done;
		logic       out_free;
	} dp_sts_t;

endpackage

/* src/mpft_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module mpft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/mpft_ctrl.sv */
// controller fsm: sequences clear, fill, pixel, read, cursor, load and char work
// depends on mpft_pkg and the assertion macro header
`include "mono_page_framebuffer_text_top_macros.svh"

module mpft_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output mpft_pkg::ctl_cmd_t cmd,
	input  mpft_pkg::dp_sts_t  sts
);
	import mpft_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b000_0000_0001,
		S_IDLE    = 11'b000_0000_0010,
		S_DECODE  = 11'b000_0000_0100,
		S_PIX_WR  = 11'b000_0000_1000,
		S_FILL    = 11'b000_0001_0000,
		S_RD_LAT  = 11'b000_0010_0000,
		S_CH_ROW  = 11'b000_0100_0000,
		S_CH_GLAT = 11'b000_1000_0000,
		S_CH_COL  = 11'b001_0000_0000,
		S_CH_WR   = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.status_val = STAT_DONE;
		state_nx       = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode     = 1'b1;
				cmd.set_status = 1'b1;
				state_nx       = S_DONE;
				case (sts.mode)
					MODE_PIXEL: begin
						if (sts.pix_ok) begin
							cmd.fb_rd = 1'b1;
							state_nx  = S_PIX_WR;
						end else begin
							cmd.status_val = STAT_NOROOM;
						end
					end
					MODE_FILL: begin
						state_nx = S_FILL;
					end
					MODE_CURSOR: begin
						cmd.cur_set = 1'b1;
					end
					MODE_CHAR: begin
						if (!sts.code_ok) begin
							cmd.status_val = STAT_BADCODE;
						end else if (!sts.room_ok) begin
							cmd.status_val = STAT_NOROOM;
						end else begin
							cmd.row_clr = 1'b1;
							state_nx    = S_CH_ROW;
						end
					end
					MODE_LOAD: begin
						if (sts.load_ok) begin
							cmd.gl_wr = 1'b1;
						end else begin
							cmd.status_val = STAT_NOROOM;
						end
					end
					MODE_READ: begin
						if (sts.read_ok) begin
							cmd.fb_rd_byte = 1'b1;
							state_nx       = S_RD_LAT;
						end else begin
							cmd.status_val = STAT_NOROOM;
						end
					end
					default: begin
						state_nx = S_DONE;
					end
				endcase
			end
			S_PIX_WR: begin
				cmd.fb_wr_pix = 1'b1;
				state_nx      = S_DONE;
			end
			S_FILL: begin
				cmd.sweep_wr   = 1'b1;
				cmd.sweep_fill = 1'b1;
				if (sts.sweep_last) begin
					state_nx = S_DONE;
				end
			end
			S_RD_LAT: begin
				cmd.rd_latch = 1'b1;
				state_nx     = S_DONE;
			end
			S_CH_ROW: begin
				cmd.pix_char = 1'b1;
				if (sts.row_done) begin
					cmd.cur_adv = 1'b1;
					state_nx    = S_DONE;
				end else begin
					cmd.gl_rd = 1'b1;
					state_nx  = S_CH_GLAT;
				end
			end
			S_CH_GLAT: begin
				cmd.pix_char = 1'b1;
				cmd.gl_latch = 1'b1;
				cmd.col_clr  = 1'b1;
				state_nx     = S_CH_COL;
			end
			S_CH_COL: begin
				cmd.pix_char = 1'b1;
				if (sts.col_done) begin
					cmd.row_inc = 1'b1;
					state_nx    = S_CH_ROW;
				end else begin
					cmd.fb_rd = 1'b1;
					state_nx  = S_CH_WR;
				end
			end
			S_CH_WR: begin
				cmd.pix_char  = 1'b1;
				cmd.fb_wr_pix = 1'b1;
				cmd.col_inc   = 1'b1;
				state_nx      = S_CH_COL;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	`MPFT_ASSERT_NXT(a_accept_to_decode, clk, arst_n, (state_q == S_IDLE) && in_valid, state_q == S_DECODE, "accepted item did not move to decode")
	`MPFT_ASSERT_IMP(a_char_write_legal, clk, arst_n, state_q == S_CH_WR, sts.code_ok && sts.room_ok, "character pixel write without a legal character")
	`MPFT_ASSERT_IMP(a_glyph_write_legal, clk, arst_n, cmd.gl_wr, sts.load_ok && (sts.mode == MODE_LOAD), "glyph write outside a legal load")

endmodule

/* src/mpft_dpath.sv */
// datapath: item and config registers, cursor, counters, address math and both stores
// depends on mpft_pkg, mpft_ram and the assertion macro header
`include "mono_page_framebuffer_text_top_macros.svh"

module mpft_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         mode,
	input  logic [7:0]         x_pos,
	input  logic [7:0]         y_pos,
	input  logic               color,
	input  logic [7:0]         char_code,
	input  logic [11:0]        glyph_index,
	input  logic [15:0]        glyph_word,
	input  logic [8:0]         byte_index,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [5:0]         cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [7:0]         read_data,
	output logic [7:0]         cursor_x,
	output logic [7:0]         cursor_y,
	input  mpft_pkg::ctl_cmd_t cmd,
	output mpft_pkg::dp_sts_t  sts
);
	import mpft_pkg::*;

	function automatic logic [FB_AW-1:0] fb_byte_addr(input logic [8:0] px, input logic [8:0] py);
		logic [FB_CALC_W-1:0] a;
		a = FB_CALC_W'(px) + FB_CALC_W'(py[8:3]) * FB_CALC_W'(SCREEN_WIDTH);
		return a[FB_AW-1:0];
	endfunction

	// latched item
	logic [2:0]  mode_q;
	logic [7:0]  x_q, y_q, code_q;
	logic        color_q;
	logic [11:0] gidx_q;
	logic [15:0] gword_q;
	logic [8:0]  bidx_q;

	logic       invert_q;
	logic [4:0] gwidth_q;
	logic [5:0] gheight_q;
	logic [7:0] cur_col_q, cur_row_q;

	logic [FB_AW-1:0]     sweep_q;
	logic [5:0]           row_q;
	logic [4:0]           col_q;
	logic [GL_CALC_W-1:0] base_q;
	logic [15:0]          bits_q;
	logic                 gzero_q;
	status_t              status_q;
	logic [7:0]           rdata_q;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [7:0] out_rdata_q, out_cx_q, out_cy_q;

	logic [8:0]           px, py, cpx, cpy;
	logic [FB_AW-1:0]     pix_addr, byte_addr;
	logic [FB_CALC_W-1:0] bidx_ext;
	logic [7:0]           mask, new_byte, fill_byte;
	logic                 glyph_on, pix_color;
	logic [6:0]           code_off;
	logic [GL_CALC_W-1:0] base_nx, gaddr, gidx_ext;
	logic                 out_free;

	logic             fb_we, fb_re;
	logic [FB_AW-1:0] fb_waddr, fb_raddr;
	logic [7:0]       fb_wdata, fb_rdata;
	logic [15:0]      gl_rdata;

	// address and pixel math
	assign cpx       = {1'b0, cur_col_q} + 9'(col_q);
	assign cpy       = {1'b0, cur_row_q} + 9'(row_q);
	assign px        = cmd.pix_char ? cpx : {1'b0, x_q};
	assign py        = cmd.pix_char ? cpy : {1'b0, y_q};
	assign pix_addr  = fb_byte_addr(px, py);
	assign bidx_ext  = FB_CALC_W'(bidx_q);
	assign byte_addr = bidx_ext[FB_AW-1:0];
	assign mask      = 8'b1 << py[2:0];
	assign glyph_on  = !col_q[4] && bits_q[4'd15 - col_q[3:0]];
	assign pix_color = (cmd.pix_char ? (glyph_on ? color_q : !color_q) : color_q) ^ invert_q;
	assign new_byte  = pix_color ? (fb_rdata | mask) : (fb_rdata & ~mask);
	assign fill_byte = (cmd.sweep_fill && color_q) ? BYTE_ONES : BYTE_ZERO;

	assign code_off = 7'(code_q - CODE_FIRST);
	assign base_nx  = GL_CALC_W'(code_off) * GL_CALC_W'(gheight_q);
	assign gaddr    = base_q + GL_CALC_W'(row_q);
	assign gidx_ext = GL_CALC_W'(gidx_q);

	assign out_free = !out_valid_q || !out_stall;

	// status toward the controller
	always_comb begin
		sts.mode       = mode_q;
		sts.pix_ok     = ({1'b0, x_q} < 9'(SCREEN_WIDTH)) && ({1'b0, y_q} < 9'(SCREEN_HEIGHT));
		sts.code_ok    = (code_q >= CODE_FIRST) && (code_q <= CODE_LAST);
		sts.room_ok    = (({1'b0, cur_col_q} + 9'(gwidth_q)) < 9'(SCREEN_WIDTH)) &&
		                 (({1'b0, cur_row_q} + 9'(gheight_q)) < 9'(SCREEN_HEIGHT));
		sts.load_ok    = gidx_ext < GL_CALC_W'(GLYPH_WORDS);
		sts.read_ok    = bidx_ext < FB_CALC_W'(FB_BYTES);
		sts.sweep_last = (sweep_q == FB_AW'(FB_BYTES - 1));
		sts.row_done   = (row_q == gheight_q);
		sts.col_done   = (col_q == gwidth_q);
		sts.out_free   = out_free;
	end

	// item payload, working registers and result fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			x_q     <= x_pos;
			y_q     <= y_pos;
			color_q <= color;
			code_q  <= char_code;
			gidx_q  <= glyph_index;
			gword_q <= glyph_word;
			bidx_q  <= byte_index;
		end
		if (cmd.decode) begin
			base_q <= base_nx;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_val;
		end
		if (cmd.capture) begin
			rdata_q <= BYTE_ZERO;
		end else if (cmd.rd_latch) begin
			rdata_q <= fb_rdata;
		end
		if (cmd.row_clr) begin
			row_q <= '0;
		end else if (cmd.row_inc) begin
			row_q <= row_q + 6'd1;
		end
		if (cmd.col_clr) begin
			col_q <= '0;
		end else if (cmd.col_inc) begin
			col_q <= col_q + 5'd1;
		end
		if (cmd.gl_rd) begin
			gzero_q <= !(gaddr < GL_CALC_W'(GLYPH_WORDS));
		end
		if (cmd.gl_latch) begin
			bits_q <= gzero_q ? 16'h0000 : gl_rdata;
		end
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_rdata_q  <= rdata_q;
			out_cx_q     <= cur_col_q;
			out_cy_q     <= cur_row_q;
		end
	end

	// config, cursor, sweep counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			gwidth_q    <= 5'd7;
			gheight_q   <= 6'd10;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_INVERT:  invert_q  <= cfg_data[0];
					CFG_GWIDTH:  gwidth_q  <= cfg_data[4:0];
					CFG_GHEIGHT: gheight_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.cur_set) begin
				cur_col_q <= x_q;
				cur_row_q <= y_q;
			end else if (cmd.cur_adv) begin
				cur_col_q <= cur_col_q + 8'(gwidth_q);
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + FB_AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame store ports
	assign fb_we    = cmd.sweep_wr || cmd.fb_wr_pix;
	assign fb_waddr = cmd.sweep_wr ? sweep_q : pix_addr;
	assign fb_wdata = cmd.sweep_wr ? fill_byte : new_byte;
	assign fb_re    = cmd.fb_rd || cmd.fb_rd_byte;
	assign fb_raddr = cmd.fb_rd_byte ? byte_addr : pix_addr;

	mpft_ram #(
		.WIDTH (8),
		.DEPTH (FB_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (fb_re),
		.raddr (fb_raddr),
		.rdata (fb_rdata)
	);

	mpft_ram #(
		.WIDTH (16),
		.DEPTH (GLYPH_WORDS)
	) u_glyph_ram (
		.clk   (clk),
		.we    (cmd.gl_wr),
		.waddr (gidx_ext[GL_AW-1:0]),
		.wdata (gword_q),
		.re    (cmd.gl_rd),
		.raddr (gaddr[GL_AW-1:0]),
		.rdata (gl_rdata)
	);

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign read_data = out_rdata_q;
	assign cursor_x  = out_cx_q;
	assign cursor_y  = out_cy_q;

	`MPFT_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall, "result loaded over an untaken result")
	`MPFT_ASSERT_IMP(a_sweep_in_range, clk, arst_n, cmd.sweep_wr, FB_CALC_W'(sweep_q) < FB_CALC_W'(FB_BYTES), "sweep address beyond the frame store")

endmodule

/* src/mono_page_framebuffer_text_top.sv */
// cursor, load, unused and clipped pixel items end at decode; pixel: frame read then write; read:
// frame read; fill: sweep of all FB_BYTES bytes; character: per glyph row (height h) a glyph
// read, then per column (width w) a pixel read-modify-write in the single frame store; rejected
// characters end at decode; one item in flight; the next transaction is taken while a finished
// result waits at the output; reset: async active low; clears cursor and config, then a clearing
// pass zeroes the frame store, during which input is stalled but config writes go in
module mono_page_framebuffer_text_top (
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_pos,
	input  logic        color,
	input  logic [7:0]  char_code,
	input  logic [11:0] glyph_index,
	input  logic [15:0] glyph_word,
	input  logic [8:0]  byte_index,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  read_data,
	output logic [7:0]  cursor_x,
	output logic [7:0]  cursor_y
);
	import mpft_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     cfg_we;

	// config registers are plain flops, a write lands in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: decides per item which datapath steps run in which cycle
	mpft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: holds the item, cursor, config, counters, frame and glyph stores,
	// and the output register that decouples the result transaction
	mpft_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.color       (color),
		.char_code   (char_code),
		.glyph_index (glyph_index),
		.glyph_word  (glyph_word),
		.byte_index  (byte_index),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.read_data   (read_data),
		.cursor_x    (cursor_x),
		.cursor_y    (cursor_y),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
